// ----- hw/rtl/skyline_atlas_allocator_unit_macros.svh -----
// Assertion macros for the checker file of the skyline atlas allocator.
`ifndef SKYLINE_ATLAS_ALLOCATOR_UNIT_MACROS_SVH
`define SKYLINE_ATLAS_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SKYATL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SKYATL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/skyatl_pkg.sv -----
// Package: field widths, word layouts and result type of the skyline atlas allocator.
`timescale 1ns / 1ps

package skyatl_pkg;

    // request fields
    localparam int RECT_W      = 9;
    localparam int IN_TDATA_W  = 24;

    // result fields
    localparam int PAGE_W      = 1;
    localparam int POS_W       = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;

    typedef struct packed {
        logic             placed;
        logic [PAGE_W-1:0] page_index;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
    } t_result;

endpackage

// ----- hw/rtl/skyline_atlas_allocator_unit.sv -----
// Top level of the skyline atlas allocator: sequencer, scan datapath and column stores.
`timescale 1ns / 1ps
//
// Usage
//   Input stream: one word per request, rect_width and rect_height. Output stream:
//   one word per request with page_index, pos_x, pos_y; tuser carries the placed flag.
//   A request that fits nowhere (or has a zero size, or is wider than a page)
//   returns placed = 0 with all data fields zero and leaves the atlas untouched.
//   Each page is searched with two sweeps over its column heights held in the
//   column RAM: a forward sweep stores block-wise prefix maxima in a scratch RAM,
//   a backward sweep forms block-wise suffix maxima and combines both into the
//   maximum of every window of rect_width columns, one column per cycle.
//   The search time is set by the one-column-per-cycle read port of the column
//   RAM; a placed request then writes its new height into each of its rect_width
//   columns. A rejected request skips the search and goes straight to S_RESULT.
//   Requests are taken one at a time; s_axis_tready is high only while idle.
//   A finished result sits in an output register, so the next request is taken
//   while that result waits on m_axis_tready; a stalled receiver holds the word.
//   After reset the column RAM is swept to zero; no request is taken until the
//   sweep is complete.
//
module skyline_atlas_allocator_unit
    import skyatl_pkg::*;
#(
    parameter int PAGES        = 2,
    parameter int ATLAS_WIDTH  = 256,
    parameter int ATLAS_HEIGHT = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request: [8:0] rect_width, [17:9] rect_height, [23:18] zero
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result: [0] page_index, [8:1] pos_x, [16:9] pos_y, [23:17] zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // result flag: [0] placed
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    localparam int AW  = $clog2(ATLAS_WIDTH);
    localparam int HW  = $clog2(ATLAS_HEIGHT + 1);
    localparam int CAW = $clog2(PAGES * ATLAS_WIDTH);
    localparam int PGW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int XW  = (((AW + 1) > RECT_W) ? (AW + 1) : RECT_W) + 1;
    localparam int SW  = ((HW > RECT_W) ? HW : RECT_W) + 1;

    localparam logic [AW-1:0]  LAST_COL  = AW'(ATLAS_WIDTH - 1);
    localparam logic [CAW-1:0] LAST_CELL = CAW'(PAGES * ATLAS_WIDTH - 1);
    localparam logic [HW-1:0]  TOP_H     = HW'(ATLAS_HEIGHT);

    // sequencer codes
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_FWD    = 3'd2;
    localparam logic [2:0] S_BWD    = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    // control state
    logic [2:0]      r_state,  n_state;
    logic [CAW-1:0]  r_caddr,  n_caddr;
    logic            r_ovld,   n_ovld;
    logic            r_d_vld,  n_d_vld;
    logic            r_done,   n_done;

    // request and scan payload
    logic [RECT_W-1:0] r_h,       n_h;
    logic [RECT_W-1:0] r_wm1,     n_wm1;
    logic [AW-1:0]     r_lim,     n_lim;
    logic [PGW-1:0]    r_page,    n_page;
    logic [CAW-1:0]    r_base,    n_base;
    logic [AW-1:0]     r_idx,     n_idx;
    logic [RECT_W-1:0] r_off,     n_off;
    logic [RECT_W-1:0] r_off_end, n_off_end;
    logic [AW-1:0]     r_d_idx,   n_d_idx;
    logic [RECT_W-1:0] r_d_off,   n_d_off;
    logic              r_d_first, n_d_first;
    logic              r_d_win,   n_d_win;
    logic [HW-1:0]     r_run,     n_run;
    logic [HW-1:0]     r_best,    n_best;
    logic [AW-1:0]     r_bx,      n_bx;
    logic              r_found,   n_found;
    logic [AW-1:0]     r_xend,    n_xend;
    logic [HW-1:0]     r_fill,    n_fill;
    t_result           r_res,     n_res;
    t_result           r_out,     n_out;

    // memory ports
    logic            col_we;
    logic [CAW-1:0]  col_waddr;
    logic [HW-1:0]   col_wdata;
    logic [CAW-1:0]  col_raddr;
    logic [HW-1:0]   col_rdata;
    logic            scr_we;
    logic [AW-1:0]   scr_raddr;
    logic [HW-1:0]   scr_rdata;

    // datapath
    logic [RECT_W-1:0] in_w;
    logic [RECT_W-1:0] in_h;
    logic              in_reject;
    logic              in_acc;
    logic              run_restart;
    logic [HW-1:0]     run_max;
    logic [HW-1:0]     win_top;
    logic              win_take;
    logic              fits;
    logic              out_load;
    logic [RECT_W-1:0] off_inc;
    logic [RECT_W-1:0] off_dec;

    // column heights of all pages
    skyatl_ram #(
        .WIDTH (HW),
        .DEPTH (PAGES * ATLAS_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    // block-wise prefix maxima of the page under search
    skyatl_ram #(
        .WIDTH (HW),
        .DEPTH (ATLAS_WIDTH)
    ) u_scr_ram (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (r_d_idx),
        .i_wdata (run_max),
        .i_raddr (scr_raddr),
        .o_rdata (scr_rdata)
    );

    // request decode
    assign in_w      = s_axis_tdata[RECT_W-1:0];
    assign in_h      = s_axis_tdata[2*RECT_W-1:RECT_W];
    assign in_reject = (in_w == '0) || (in_h == '0) ||
                       (XW'(in_w) > XW'(ATLAS_WIDTH));
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // memory addressing
    assign col_raddr = r_base + CAW'(r_idx);
    assign scr_raddr = r_idx + AW'(r_wm1);
    assign col_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign col_waddr = (r_state == S_CLEAR) ? r_caddr : col_raddr;
    assign col_wdata = (r_state == S_CLEAR) ? '0 : r_fill;
    assign scr_we    = (r_state == S_FWD) && r_d_vld;

    // running block maximum: prefix going forward, suffix going backward
    assign run_restart = (r_state == S_FWD) ? (r_d_off == '0)
                                            : ((r_d_off == r_wm1) || r_d_first);
    assign run_max = (run_restart || (col_rdata > r_run)) ? col_rdata : r_run;

    // window maximum and lowest-then-leftmost choice
    assign win_top  = (run_max > scr_rdata) ? run_max : scr_rdata;
    assign win_take = (r_state == S_BWD) && r_d_vld && r_d_win && (win_top < TOP_H) &&
                      (!r_found || (win_top <= r_best));
    assign fits     = r_found && ((SW'(r_best) + SW'(r_h)) <= SW'(ATLAS_HEIGHT));

    // block offset counters
    assign off_inc = (r_off == r_wm1) ? '0 : r_off + 1'b1;
    assign off_dec = (r_off == '0) ? r_wm1 : r_off - 1'b1;

    assign out_load = (r_state == S_RESULT) && (!r_ovld || m_axis_tready);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_caddr   = r_caddr;
        n_d_vld   = 1'b0;
        n_done    = r_done;
        n_h       = r_h;
        n_wm1     = r_wm1;
        n_lim     = r_lim;
        n_page    = r_page;
        n_base    = r_base;
        n_idx     = r_idx;
        n_off     = r_off;
        n_off_end = r_off_end;
        n_d_idx   = r_idx;
        n_d_off   = r_off;
        n_d_first = (r_idx == LAST_COL);
        n_d_win   = (r_idx <= r_lim);
        n_run     = r_d_vld ? run_max : r_run;
        n_best    = r_best;
        n_bx      = r_bx;
        n_found   = r_found;
        n_xend    = r_xend;
        n_fill    = r_fill;
        n_res     = r_res;
        n_out     = r_out;
        n_ovld    = r_ovld;

        if (win_take) begin
            n_best  = win_top;
            n_bx    = r_d_idx;
            n_found = 1'b1;
        end

        unique case (r_state)
            S_CLEAR: begin
                n_caddr = r_caddr + 1'b1;
                if (r_caddr == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res = '0;
                    if (in_reject) begin
                        n_state = S_RESULT;
                    end else begin
                        n_h     = in_h;
                        n_wm1   = in_w - 1'b1;
                        n_lim   = AW'(XW'(ATLAS_WIDTH) - XW'(in_w));
                        n_page  = '0;
                        n_base  = '0;
                        n_idx   = '0;
                        n_off   = '0;
                        n_done  = 1'b0;
                        n_found = 1'b0;
                        n_state = S_FWD;
                    end
                end
            end
            S_FWD: begin
                if (!r_done) begin
                    n_d_vld = 1'b1;
                    n_off   = off_inc;
                    if (r_idx == LAST_COL) begin
                        n_done    = 1'b1;
                        n_off_end = r_off;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (!r_d_vld) begin
                    n_idx   = LAST_COL;
                    n_off   = r_off_end;
                    n_done  = 1'b0;
                    n_state = S_BWD;
                end
            end
            S_BWD: begin
                if (!r_done) begin
                    n_d_vld = 1'b1;
                    n_off   = off_dec;
                    if (r_idx == '0) begin
                        n_done = 1'b1;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end else if (!r_d_vld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (fits) begin
                    n_fill           = HW'(SW'(r_best) + SW'(r_h));
                    n_idx            = r_bx;
                    n_xend           = r_bx + AW'(r_wm1);
                    n_res.placed     = 1'b1;
                    n_res.page_index = r_page[0];
                    n_res.pos_x      = POS_W'(r_bx);
                    n_res.pos_y      = POS_W'(r_best);
                    n_state          = S_WRITE;
                end else if (r_page == PGW'(PAGES - 1)) begin
                    n_state = S_RESULT;
                end else begin
                    n_page  = r_page + 1'b1;
                    n_base  = r_base + CAW'(ATLAS_WIDTH);
                    n_idx   = '0;
                    n_off   = '0;
                    n_done  = 1'b0;
                    n_found = 1'b0;
                    n_state = S_FWD;
                end
            end
            S_WRITE: begin
                if (r_idx == r_xend) begin
                    n_state = S_RESULT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_caddr = '0;
            end
        endcase

        // output register
        if (out_load) begin
            n_out  = r_res;
            n_ovld = 1'b1;
        end else if (r_ovld && m_axis_tready) begin
            n_ovld = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_caddr <= '0;
            r_ovld  <= 1'b0;
            r_d_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_caddr <= n_caddr;
            r_ovld  <= n_ovld;
            r_d_vld <= n_d_vld;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_h       <= n_h;
        r_wm1     <= n_wm1;
        r_lim     <= n_lim;
        r_page    <= n_page;
        r_base    <= n_base;
        r_idx     <= n_idx;
        r_off     <= n_off;
        r_off_end <= n_off_end;
        r_d_idx   <= n_d_idx;
        r_d_off   <= n_d_off;
        r_d_first <= n_d_first;
        r_d_win   <= n_d_win;
        r_run     <= n_run;
        r_best    <= n_best;
        r_bx      <= n_bx;
        r_found   <= n_found;
        r_xend    <= n_xend;
        r_fill    <= n_fill;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.pos_y, r_out.pos_x, r_out.page_index});
    assign m_axis_tuser  = OUT_TUSER_W'(r_out.placed);

endmodule

// ----- hw/rtl/skyatl_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module skyatl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/skyatl_chk.sv -----
// Port-level checker for the skyline atlas allocator and its bind.
`timescale 1ns / 1ps
`include "skyline_atlas_allocator_unit_macros.svh"

module skyatl_chk
    import skyatl_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // a stalled result word holds
    `SKYATL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed under stall")

    // a failed placement reports zero position fields
    `SKYATL_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "failed placement with nonzero fields")

    // one request in flight: ready drops right after a request word is taken
    `SKYATL_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")

endmodule

bind skyline_atlas_allocator_unit skyatl_chk u_skyatl_chk (.*);
